[hw/rtl/sparse_min_plus_block_update_assert.svh]
// Assertion macros shared by the sparse min-plus block update modules.
`ifndef SPARSE_MIN_PLUS_BLOCK_UPDATE_ASSERT_SVH
`define SPARSE_MIN_PLUS_BLOCK_UPDATE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SMPBU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SMPBU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/smpbu_pkg.sv]
// Package with types, codes and helpers of the sparse min-plus block update.
package smpbu_pkg;

  // Sizes of the stores.
  localparam int V      = 64;
  localparam int B      = 16;
  localparam int WB     = 32;
  localparam int VW     = 6;
  localparam int BW     = 4;
  localparam int CW     = 7;
  localparam int DA_W   = 2 * VW;
  localparam int CA_W   = VW + BW;

  localparam logic [WB-1:0] W_INF = '1;

  // Request command codes.
  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_RANGE  = 3'd1;
  localparam logic [2:0] CMD_EDGE   = 3'd2;
  localparam logic [2:0] CMD_UPDATE = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  // Datapath micro-operations issued by the controller.
  typedef logic [4:0] uop_t;
  localparam uop_t UOP_NOP      = 5'd0;
  localparam uop_t UOP_CAPTURE  = 5'd1;
  localparam uop_t UOP_CLR      = 5'd2;
  localparam uop_t UOP_RANGE_WR = 5'd3;
  localparam uop_t UOP_EDGE0    = 5'd4;
  localparam uop_t UOP_EDGE1    = 5'd5;
  localparam uop_t UOP_EDGE2    = 5'd6;
  localparam uop_t UOP_RD       = 5'd7;
  localparam uop_t UOP_RD_LATCH = 5'd8;
  localparam uop_t UOP_RNG_I    = 5'd9;
  localparam uop_t UOP_RNG_J    = 5'd10;
  localparam uop_t UOP_RNG_K    = 5'd11;
  localparam uop_t UOP_K0       = 5'd12;
  localparam uop_t UOP_K1       = 5'd13;
  localparam uop_t UOP_KNEXT    = 5'd14;
  localparam uop_t UOP_A0       = 5'd15;
  localparam uop_t UOP_A1       = 5'd16;
  localparam uop_t UOP_A2       = 5'd17;
  localparam uop_t UOP_ANEXT    = 5'd18;
  localparam uop_t UOP_P0       = 5'd19;
  localparam uop_t UOP_P1       = 5'd20;
  localparam uop_t UOP_P2       = 5'd21;
  localparam uop_t UOP_P3       = 5'd22;
  localparam uop_t UOP_P4       = 5'd23;
  localparam uop_t UOP_RESP     = 5'd24;

  // Input request payload.
  typedef struct packed {
    logic [2:0]    command;
    logic [VW-1:0] row;
    logic [VW-1:0] col;
    logic [WB-1:0] weight;
    logic [BW-1:0] row_block;
    logic [BW-1:0] col_block;
    logic [BW-1:0] pivot_block;
    logic [6:0]    range_first;
    logic [6:0]    range_end;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic [WB-1:0] read_value;
    logic          status;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    uop_t uop;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] cmd;
    logic       bad;
    logic       clr_last;
    logic       k_more;
    logic       a_more;
    logic       b_more;
    logic       grow;
  } dp_stat_t;

  // Saturating add: anything reaching all ones is infinity.
  function automatic logic [WB-1:0] sat_add(input logic [WB-1:0] a, input logic [WB-1:0] b);
    logic [WB:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == W_INF || b == W_INF || s >= {1'b0, W_INF}) begin
      return W_INF;
    end
    return s[WB-1:0];
  endfunction

endpackage

[hw/rtl/smpbu_ctrl.sv]
// Controller state machine that sequences the datapath micro-operations.
`include "sparse_min_plus_block_update_assert.svh"

module smpbu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  smpbu_pkg::dp_stat_t st,
  output smpbu_pkg::ctl_cmd_t cmd
);
  import smpbu_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_BOOT = 5'd1;
  localparam logic [4:0] S_DISP = 5'd2;
  localparam logic [4:0] S_CLR  = 5'd3;
  localparam logic [4:0] S_RWR  = 5'd4;
  localparam logic [4:0] S_E0   = 5'd5;
  localparam logic [4:0] S_E1   = 5'd6;
  localparam logic [4:0] S_E2   = 5'd7;
  localparam logic [4:0] S_RD   = 5'd8;
  localparam logic [4:0] S_RDL  = 5'd9;
  localparam logic [4:0] S_RI   = 5'd10;
  localparam logic [4:0] S_RJ   = 5'd11;
  localparam logic [4:0] S_RK   = 5'd12;
  localparam logic [4:0] S_K0   = 5'd13;
  localparam logic [4:0] S_K1   = 5'd14;
  localparam logic [4:0] S_A0   = 5'd15;
  localparam logic [4:0] S_A1   = 5'd16;
  localparam logic [4:0] S_A2   = 5'd17;
  localparam logic [4:0] S_P0   = 5'd18;
  localparam logic [4:0] S_P1   = 5'd19;
  localparam logic [4:0] S_P2   = 5'd20;
  localparam logic [4:0] S_P3   = 5'd21;
  localparam logic [4:0] S_P4   = 5'd22;
  localparam logic [4:0] S_RESP = 5'd23;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  uop_t       uop;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign cmd.uop   = uop;

  // Next state and micro-operation.
  always_comb begin
    state_nxt     = state_r;
    uop           = UOP_NOP;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_BOOT: begin
        uop = UOP_CLR;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          uop       = UOP_CAPTURE;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (st.cmd)
          CMD_CLEAR:  state_nxt = S_CLR;
          CMD_RANGE:  state_nxt = S_RWR;
          CMD_EDGE:   state_nxt = st.bad ? S_RESP : S_E0;
          CMD_UPDATE: state_nxt = S_RI;
          CMD_READ:   state_nxt = st.bad ? S_RESP : S_RD;
          default:    state_nxt = S_RESP;
        endcase
      end
      S_CLR: begin
        uop = UOP_CLR;
        if (st.clr_last) state_nxt = S_RESP;
      end
      S_RWR: begin
        uop       = UOP_RANGE_WR;
        state_nxt = S_RESP;
      end
      S_E0: begin
        uop       = UOP_EDGE0;
        state_nxt = S_E1;
      end
      S_E1: begin
        uop       = UOP_EDGE1;
        state_nxt = S_E2;
      end
      S_E2: begin
        uop       = UOP_EDGE2;
        state_nxt = S_RESP;
      end
      S_RD: begin
        uop       = UOP_RD;
        state_nxt = S_RDL;
      end
      S_RDL: begin
        uop       = UOP_RD_LATCH;
        state_nxt = S_RESP;
      end
      S_RI: begin
        uop       = UOP_RNG_I;
        state_nxt = S_RJ;
      end
      S_RJ: begin
        uop       = UOP_RNG_J;
        state_nxt = S_RK;
      end
      S_RK: begin
        uop       = UOP_RNG_K;
        state_nxt = S_K0;
      end
      S_K0: begin
        if (st.k_more) begin
          uop       = UOP_K0;
          state_nxt = S_K1;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_K1: begin
        uop       = UOP_K1;
        state_nxt = S_A0;
      end
      S_A0: begin
        if (st.a_more) begin
          uop       = UOP_A0;
          state_nxt = S_A1;
        end else begin
          uop       = UOP_KNEXT;
          state_nxt = S_K0;
        end
      end
      S_A1: begin
        uop       = UOP_A1;
        state_nxt = S_A2;
      end
      S_A2: begin
        uop       = UOP_A2;
        state_nxt = S_P0;
      end
      S_P0: begin
        if (st.b_more) begin
          uop       = UOP_P0;
          state_nxt = S_P1;
        end else begin
          uop       = UOP_ANEXT;
          state_nxt = S_A0;
        end
      end
      S_P1: begin
        uop       = UOP_P1;
        state_nxt = S_P2;
      end
      S_P2: begin
        uop       = UOP_P2;
        state_nxt = S_P3;
      end
      S_P3: begin
        uop       = UOP_P3;
        state_nxt = st.grow ? S_P4 : S_P0;
      end
      S_P4: begin
        uop       = UOP_P4;
        state_nxt = S_P0;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          uop           = UOP_RESP;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BOOT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SMPBU_ASSERT_NEXT(a_accept_dispatch, state_r == S_IDLE && in_valid, state_r == S_DISP, "accepted request not dispatched")
  `SMPBU_ASSERT_NEXT(a_boot_silent, state_r == S_BOOT && st.clr_last, state_r == S_IDLE && !out_valid_r, "boot clear produced a result")
  `SMPBU_ASSERT_NEXT(a_resp_loaded, uop == UOP_RESP, out_valid_r && state_r == S_IDLE, "result not presented")

endmodule

[hw/rtl/smpbu_dp.sv]
// Datapath: distance, list and count memories, block ranges and relaxation logic.
`include "sparse_min_plus_block_update_assert.svh"

module smpbu_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  smpbu_pkg::req_t     in_data,
  output smpbu_pkg::rsp_t     out_data,
  input  logic                cfg_wr_en,
  input  logic [6:0]          cfg_wr_data,
  input  smpbu_pkg::ctl_cmd_t cmd,
  output smpbu_pkg::dp_stat_t st
);
  import smpbu_pkg::*;

  // Memories.
  logic [WB-1:0] dist_mem [1 << DA_W];
  logic [VW-1:0] inl_mem  [1 << DA_W];
  logic [VW-1:0] outl_mem [1 << DA_W];
  logic [CW-1:0] inc_mem  [1 << CA_W];
  logic [CW-1:0] outc_mem [1 << CA_W];

  logic [WB-1:0]   dist_rd_r;
  logic [VW-1:0]   inl_rd_r, outl_rd_r;
  logic [CW-1:0]   inc_rd_r, outc_rd_r;

  logic            dist_we, inl_we, outl_we, inc_we, outc_we;
  logic [DA_W-1:0] dist_wa, dist_ra, inl_wa, inl_ra, outl_wa, outl_ra;
  logic [CA_W-1:0] inc_wa, inc_ra, outc_wa, outc_ra;
  logic [WB-1:0]   dist_wd;
  logic [VW-1:0]   inl_wd, outl_wd;
  logic [CW-1:0]   inc_wd, outc_wd;

  // Control and working registers.
  req_t            req_r;
  logic [6:0]      vcount_r;
  logic [DA_W-1:0] clr_addr_r;
  logic [6:0]      rng_start_r [B];
  logic [6:0]      rng_end_r   [B];
  logic [6:0]      rs_i_r, re_i_r, rs_j_r, re_j_r, k_r, kend_r;
  logic [CW-1:0]   nin_r, nout_r, a_r, b_r;
  logic [VW-1:0]   from_r, to_r;
  logic [WB-1:0]   dik_r, dkj_r, res_val_r;
  rsp_t            out_r;

  logic [6:0]      nv;
  logic            bad, upd;
  logic [BW-1:0]   rng_idx;
  logic [6:0]      rng_s, rng_e;
  logic [7:0]      sa, sb, in_slot, out_slot;
  logic            in_ok, out_ok, do_in_app, do_out_app;
  logic [VW-1:0]   in_v, in_val, out_v, out_val;
  logic [WB-1:0]   cand;
  logic            relax;

  assign out_data = out_r;

  // Vertex count in use and request checks.
  assign nv  = (vcount_r > 7'(V)) ? 7'(V) : vcount_r;
  assign upd = (req_r.command == CMD_UPDATE);
  always_comb begin
    case (req_r.command)
      CMD_RANGE: bad = (req_r.range_first > req_r.range_end) || (req_r.range_end > 7'(V));
      CMD_EDGE, CMD_READ:
        bad = ({1'b0, req_r.row} >= nv) || ({1'b0, req_r.col} >= nv);
      default:   bad = 1'b0;
    endcase
  end

  // Block range lookup, one block per cycle.
  always_comb begin
    if (cmd.uop inside {UOP_RNG_I, UOP_EDGE0}) begin
      rng_idx = req_r.row_block;
    end else if (cmd.uop inside {UOP_RNG_J, UOP_EDGE1}) begin
      rng_idx = req_r.col_block;
    end else begin
      rng_idx = req_r.pivot_block;
    end
  end
  assign rng_s = rng_start_r[rng_idx];
  assign rng_e = rng_end_r[rng_idx];

  // List slots walked by the update loops.
  assign sa = {1'b0, rs_i_r} + {1'b0, a_r};
  assign sb = {1'b0, rs_j_r} + {1'b0, b_r};

  // Append targets: an added edge or a pair that just became finite.
  assign in_v    = upd ? to_r   : req_r.col;
  assign in_val  = upd ? from_r : req_r.row;
  assign out_v   = upd ? from_r : req_r.row;
  assign out_val = upd ? to_r   : req_r.col;
  assign in_slot  = {1'b0, rs_i_r} + {1'b0, inc_rd_r};
  assign out_slot = {1'b0, rs_j_r} + {1'b0, outc_rd_r};
  assign in_ok    = (in_slot < {1'b0, re_i_r}) && (in_slot < 8'(V));
  assign out_ok   = (out_slot < {1'b0, re_j_r}) && (out_slot < 8'(V));
  assign do_in_app  = (cmd.uop == UOP_EDGE1) || (cmd.uop == UOP_P4);
  assign do_out_app = (cmd.uop == UOP_EDGE2) || (cmd.uop == UOP_P4);

  // Relaxation through the pivot.
  assign cand  = sat_add(dik_r, dkj_r);
  assign relax = cand < dist_rd_r;

  // Status back to the controller.
  assign st.cmd      = req_r.command;
  assign st.bad      = bad;
  assign st.clr_last = (clr_addr_r == '1);
  assign st.k_more   = k_r < kend_r;
  assign st.a_more   = (a_r < nin_r) && (sa < 8'(V));
  assign st.b_more   = (b_r < nout_r) && (sb < 8'(V));
  assign st.grow     = relax && (dist_rd_r == W_INF);

  // Memory port control.
  always_comb begin
    dist_we = 1'b0;
    dist_wa = {req_r.row, req_r.col};
    dist_wd = req_r.weight;
    dist_ra = {req_r.row, req_r.col};
    inl_we  = do_in_app && in_ok;
    inl_wa  = {in_v, in_slot[VW-1:0]};
    inl_wd  = in_val;
    inl_ra  = {k_r[VW-1:0], sa[VW-1:0]};
    outl_we = do_out_app && out_ok;
    outl_wa = {out_v, out_slot[VW-1:0]};
    outl_wd = out_val;
    outl_ra = {k_r[VW-1:0], sb[VW-1:0]};
    inc_we  = do_in_app && in_ok;
    inc_wa  = {in_v, req_r.row_block};
    inc_wd  = inc_rd_r + 7'd1;
    inc_ra  = {in_v, req_r.row_block};
    outc_we = do_out_app && out_ok;
    outc_wa = {out_v, req_r.col_block};
    outc_wd = outc_rd_r + 7'd1;
    outc_ra = {out_v, req_r.col_block};
    case (cmd.uop)
      UOP_CLR: begin
        dist_we = 1'b1;
        dist_wa = clr_addr_r;
        dist_wd = (clr_addr_r[DA_W-1:VW] == clr_addr_r[VW-1:0]) ? '0 : W_INF;
        inc_we  = (clr_addr_r[DA_W-1:CA_W] == '0);
        outc_we = (clr_addr_r[DA_W-1:CA_W] == '0);
        inc_wa  = clr_addr_r[CA_W-1:0];
        outc_wa = clr_addr_r[CA_W-1:0];
        inc_wd  = '0;
        outc_wd = '0;
      end
      UOP_EDGE0: dist_we = 1'b1;
      UOP_K0: begin
        inc_ra  = {k_r[VW-1:0], req_r.row_block};
        outc_ra = {k_r[VW-1:0], req_r.col_block};
      end
      UOP_A1: dist_ra = {inl_rd_r, k_r[VW-1:0]};
      UOP_P1: dist_ra = {k_r[VW-1:0], outl_rd_r};
      UOP_P2: dist_ra = {from_r, to_r};
      UOP_P3: begin
        dist_we = relax;
        dist_wa = {from_r, to_r};
        dist_wd = cand;
      end
      default: ;
    endcase
  end

  // Distance memory.
  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    dist_rd_r <= dist_mem[dist_ra];
  end

  // In-neighbor and out-neighbor list memories.
  always_ff @(posedge clk) begin
    if (inl_we) inl_mem[inl_wa] <= inl_wd;
    inl_rd_r <= inl_mem[inl_ra];
  end
  always_ff @(posedge clk) begin
    if (outl_we) outl_mem[outl_wa] <= outl_wd;
    outl_rd_r <= outl_mem[outl_ra];
  end

  // List count memories.
  always_ff @(posedge clk) begin
    if (inc_we) inc_mem[inc_wa] <= inc_wd;
    inc_rd_r <= inc_mem[inc_ra];
  end
  always_ff @(posedge clk) begin
    if (outc_we) outc_mem[outc_wa] <= outc_wd;
    outc_rd_r <= outc_mem[outc_ra];
  end

  // Configuration, clear sweep address and block ranges.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r   <= 7'(V);
      clr_addr_r <= '0;
      for (int i = 0; i < B; i++) begin
        rng_start_r[i] <= '0;
        rng_end_r[i]   <= '0;
      end
    end else begin
      if (cfg_wr_en) vcount_r <= cfg_wr_data;
      if (cmd.uop == UOP_CLR) clr_addr_r <= clr_addr_r + DA_W'(1);
      if (cmd.uop == UOP_RANGE_WR && !bad) begin
        rng_start_r[req_r.row_block] <= req_r.range_first;
        rng_end_r[req_r.row_block]   <= req_r.range_end;
      end
    end
  end

  // Working registers of the command sequences.
  always_ff @(posedge clk) begin
    case (cmd.uop)
      UOP_CAPTURE: begin
        req_r     <= in_data;
        res_val_r <= '0;
      end
      UOP_RD_LATCH: res_val_r <= dist_rd_r;
      UOP_RNG_I, UOP_EDGE0: begin
        rs_i_r <= rng_s;
        re_i_r <= rng_e;
      end
      UOP_RNG_J, UOP_EDGE1: begin
        rs_j_r <= rng_s;
        re_j_r <= rng_e;
      end
      UOP_RNG_K: begin
        k_r    <= rng_s;
        kend_r <= (rng_e > nv) ? nv : rng_e;
      end
      UOP_K1: begin
        nin_r  <= inc_rd_r;
        nout_r <= outc_rd_r;
        a_r    <= '0;
      end
      UOP_KNEXT: k_r <= k_r + 7'd1;
      UOP_A1:    from_r <= inl_rd_r;
      UOP_A2: begin
        dik_r <= dist_rd_r;
        b_r   <= '0;
      end
      UOP_ANEXT: a_r <= a_r + 7'd1;
      UOP_P1:    to_r <= outl_rd_r;
      UOP_P2:    dkj_r <= dist_rd_r;
      UOP_P3:    b_r <= b_r + 7'd1;
      UOP_RESP: begin
        out_r.read_value <= res_val_r;
        out_r.status     <= bad;
      end
      default: ;
    endcase
  end

  `SMPBU_ASSERT_NOW(a_relax_lowers, cmd.uop == UOP_P3 && dist_we, cand < dist_rd_r, "relaxation raised a distance")
  `SMPBU_ASSERT_NOW(a_counts_bounded, cmd.uop == UOP_K1, inc_rd_r <= 7'(V) && outc_rd_r <= 7'(V), "list count beyond vertex limit")
  `SMPBU_ASSERT_NOW(a_pivot_bounded, cmd.uop == UOP_K0, k_r < 7'(V), "pivot beyond vertex limit")

endmodule

[hw/rtl/sparse_min_plus_block_update.sv]
// Top level of the sparse min-plus block update engine.
//
// One request gives one result. After reset the block runs a clearing pass over
// the distance matrix and accepts no request until it ends. A clear request
// repeats that pass; every request goes through dispatch and a result step.
// update_block walks every pivot, the in-neighbors of each pivot and the pairs
// behind them, appending the pairs that turn finite to the neighbor lists; the
// single read port of the distance memory means that each pair takes an
// out-list read, two distance reads and the write-back in turn. Up to 64
// pivots, 64 in-neighbors and 64 out-neighbors per pivot can be walked. A
// finished result waits in an output register while the next request is taken.
module sparse_min_plus_block_update (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  smpbu_pkg::req_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output smpbu_pkg::rsp_t out_data,
  input  logic            cfg_wr_en,
  input  logic [6:0]      cfg_wr_data
);
  import smpbu_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t st;

  // Sequencer.
  smpbu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  smpbu_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .st          (st)
  );

endmodule
